// ===== sv/psg_pkg.sv =====
`default_nettype none

package psg_pkg;

  localparam int unsigned IDX_W = 5;

  // Byte positions within one item's output run.
  localparam logic [IDX_W-1:0] IDX_HDR_FIRST  = 5'd0;
  localparam logic [IDX_W-1:0] IDX_ENTRY      = 5'd12;
  localparam logic [IDX_W-1:0] IDX_ENTRY_LAST = 5'd16;
  localparam logic [IDX_W-1:0] IDX_CRC        = 5'd17;
  localparam logic [IDX_W-1:0] IDX_CRC_LAST   = 5'd20;
  localparam logic [IDX_W-1:0] IDX_BEGIN      = 5'd31;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [7:0]  TABLE_ID_PMT = 8'h02;
  localparam logic [11:0] SECT_LEN_BASE = 12'd13;

  localparam logic [1:0] CFG_PROG_NUM    = 2'd0;
  localparam logic [1:0] CFG_PCR_PID     = 2'd1;
  localparam logic [1:0] CFG_TRACK_COUNT = 2'd2;

  typedef struct packed {
    logic [15:0] prog_num;
    logic [12:0] pcr_pid;
    logic [7:0]  track_count;
  } cfg_t;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  st_code;
    logic [12:0] es_pid;
  } item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/psg_front.sv =====
`default_nettype none

module psg_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          st_code_i,
  input  wire logic [12:0]         es_pid_i,
  input  wire logic                q_full_i,
  output logic                     q_push_o,
  output psg_pkg::item_t           q_item_o,
  output psg_pkg::cfg_t            cfg_o
);

  psg_pkg::cfg_t cfg_q;
  logic [7:0]    done_q, done_d;
  logic [7:0]    cnt, next_cnt;
  logic          accept, last;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign cnt        = (cfg_q.track_count == 8'd0) ? 8'd1 : cfg_q.track_count;
  assign next_cnt   = done_q + 8'd1;
  // wrap to zero also closes the section
  assign last       = (next_cnt == 8'd0) || (next_cnt >= cnt);

  always_comb begin
    done_d = done_q;
    if (accept) begin
      done_d = last ? 8'd0 : next_cnt;
    end
  end

  assign q_push_o         = accept;
  assign q_item_o.first   = (done_q == 8'd0);
  assign q_item_o.last    = last;
  assign q_item_o.st_code = st_code_i;
  assign q_item_o.es_pid  = es_pid_i;
  assign cfg_o            = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prog_num    <= 16'd1;
      cfg_q.pcr_pid     <= 13'd256;
      cfg_q.track_count <= 8'd1;
      done_q            <= 8'd0;
    end else begin
      done_q <= done_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          psg_pkg::CFG_PROG_NUM:    cfg_q.prog_num    <= cfg_data_i;
          psg_pkg::CFG_PCR_PID:     cfg_q.pcr_pid     <= cfg_data_i[12:0];
          psg_pkg::CFG_TRACK_COUNT: cfg_q.track_count <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/psg_queue.sv =====
`default_nettype none

module psg_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire psg_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output psg_pkg::item_t      item_o
);

  psg_pkg::item_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/psg_back.sv =====
`default_nettype none

module psg_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire psg_pkg::cfg_t  cfg_i,
  input  wire logic           q_valid_i,
  input  wire psg_pkg::item_t q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          section_byte_o,
  output logic                last_byte_o
);

  logic [psg_pkg::IDX_W-1:0] idx_q, idx_d, cur;
  logic [31:0]               crc_q, crc_d, crc_in;
  logic [7:0]                byte_d, data_q;
  logic                      valid_q, valid_d, last_q;
  logic                      advance, item_done;
  logic [7:0]                cnt;
  logic [11:0]               len;

  assign cnt = (cfg_i.track_count == 8'd0) ? 8'd1 : cfg_i.track_count;
  assign len = psg_pkg::SECT_LEN_BASE + {2'b0, cnt, 2'b0} + {4'b0, cnt};

  assign cur = (idx_q == psg_pkg::IDX_BEGIN)
             ? (q_item_i.first ? psg_pkg::IDX_HDR_FIRST : psg_pkg::IDX_ENTRY)
             : idx_q;

  assign advance   = q_valid_i && (!valid_q || out_ready_i);
  assign item_done = (cur == psg_pkg::IDX_CRC_LAST)
                  || ((cur == psg_pkg::IDX_ENTRY_LAST) && !q_item_i.last);
  assign q_pop_o   = advance && item_done;

  always_comb begin
    case (cur)
      5'd0:    byte_d = psg_pkg::TABLE_ID_PMT;
      5'd1:    byte_d = {4'hB, len[11:8]};
      5'd2:    byte_d = len[7:0];
      5'd3:    byte_d = cfg_i.prog_num[15:8];
      5'd4:    byte_d = cfg_i.prog_num[7:0];
      5'd5:    byte_d = 8'hC1;
      5'd8:    byte_d = {3'b111, cfg_i.pcr_pid[12:8]};
      5'd9:    byte_d = cfg_i.pcr_pid[7:0];
      5'd10:   byte_d = 8'hF0;
      5'd12:   byte_d = q_item_i.st_code;
      5'd13:   byte_d = {3'b111, q_item_i.es_pid[12:8]};
      5'd14:   byte_d = q_item_i.es_pid[7:0];
      5'd15:   byte_d = 8'hF0;
      5'd17:   byte_d = crc_q[31:24];
      5'd18:   byte_d = crc_q[23:16];
      5'd19:   byte_d = crc_q[15:8];
      5'd20:   byte_d = crc_q[7:0];
      default: byte_d = 8'h00;
    endcase
  end

  // header byte zero restarts the CRC
  assign crc_in = (cur == psg_pkg::IDX_HDR_FIRST) ? psg_pkg::CRC_INIT : crc_q;

  always_comb begin
    idx_d   = idx_q;
    crc_d   = crc_q;
    valid_d = valid_q;
    if (advance) begin
      valid_d = 1'b1;
      idx_d   = item_done ? psg_pkg::IDX_BEGIN : cur + 5'd1;
      if (cur < psg_pkg::IDX_CRC) begin
        crc_d = psg_pkg::crc_byte(crc_in, byte_d);
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      data_q <= byte_d;
      last_q <= (cur == psg_pkg::IDX_CRC_LAST);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= psg_pkg::IDX_BEGIN;
      crc_q   <= psg_pkg::CRC_INIT;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign section_byte_o = data_q;
  assign last_byte_o    = last_q;

endmodule

`default_nettype wire

// ===== sv/pmt_section_generator_core.sv =====
`default_nettype none

// Channel   | Dir | Handshake                    | Payload
// ----------+-----+------------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: st_code, es_pid
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: section_byte; tlast: last_byte
// cfg       | in  | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One section byte leaves per cycle while an entry waits and output is ready:
// an entry is 5 bytes, 17 if first of a section, 4 more if last (CRC bytes);
// the back-end sequencer sets this. A two-entry queue decouples input from output.
// Reset clears config to program 1, PCR PID 256, one track. No clearing pass.
// Output stalls hold the byte register; input stalls only when the queue is full.

module pmt_section_generator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] st_code, [20:8] es_pid
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] section_byte
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  psg_pkg::cfg_t  cfg;
  psg_pkg::item_t push_item, head_item;
  logic           q_full, q_push, q_pop, q_valid;

  assign cfg_ready_o = 1'b1;

  psg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .st_code_i   (s_axis_tdata[7:0]),
    .es_pid_i    (s_axis_tdata[20:8]),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item),
    .cfg_o       (cfg)
  );

  psg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  psg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .q_item_i       (head_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .section_byte_o (m_axis_tdata),
    .last_byte_o    (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== sim/pmt_section_generator_core_tb.sv =====
`timescale 1ns / 1ps

module pmt_section_generator_core_tb;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned SETTLE_CYCLES  = 32;
  localparam int unsigned RANDOM_ENTRIES = 350;
  localparam int unsigned GAP_PCT        = 17;
  // index outside the register map, expected to be ignored
  localparam logic [1:0]  CFG_SPARE      = 2'd3;

  class pmt_scoreboard;
    logic [15:0] prog_num;
    logic [12:0] pcr_pid;
    logic [7:0]  track_count;
    logic [31:0] crc;
    logic [7:0]  entries_done;
    logic [8:0]  section_bytes[$];  // {last_byte, section_byte}
    int          errors;

    function new();
      prog_num     = 16'd1;
      pcr_pid      = 13'd256;
      track_count  = 8'd1;
      crc          = psg_pkg::CRC_INIT;
      entries_done = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        psg_pkg::CFG_PROG_NUM:    prog_num = data;
        psg_pkg::CFG_PCR_PID:     pcr_pid = data[12:0];
        psg_pkg::CFG_TRACK_COUNT: track_count = data[7:0];
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] b, logic last, bit feed);
      section_bytes.push_back({last, b});
      if (feed) begin
        crc = crc ^ {b, 24'h0};
        for (int i = 0; i < 8; i++) begin
          crc = crc[31] ? ({crc[30:0], 1'b0} ^ psg_pkg::CRC_POLY) : {crc[30:0], 1'b0};
        end
      end
    endfunction

    function void note_entry(logic [7:0] st, logic [12:0] pid);
      logic [7:0]  cnt;
      logic [11:0] len;
      logic [31:0] c;
      cnt = (track_count == 8'd0) ? 8'd1 : track_count;
      if (entries_done == 8'd0) begin
        len = psg_pkg::SECT_LEN_BASE + 12'd5 * cnt;
        crc = psg_pkg::CRC_INIT;
        push_byte(psg_pkg::TABLE_ID_PMT, 1'b0, 1'b1);
        push_byte({4'hB, len[11:8]}, 1'b0, 1'b1);
        push_byte(len[7:0], 1'b0, 1'b1);
        push_byte(prog_num[15:8], 1'b0, 1'b1);
        push_byte(prog_num[7:0], 1'b0, 1'b1);
        push_byte(8'hC1, 1'b0, 1'b1);  // version 0, current
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte({3'b111, pcr_pid[12:8]}, 1'b0, 1'b1);
        push_byte(pcr_pid[7:0], 1'b0, 1'b1);
        push_byte(8'hF0, 1'b0, 1'b1);  // empty program info
        push_byte(8'h00, 1'b0, 1'b1);
      end
      push_byte(st, 1'b0, 1'b1);
      push_byte({3'b111, pid[12:8]}, 1'b0, 1'b1);
      push_byte(pid[7:0], 1'b0, 1'b1);
      push_byte(8'hF0, 1'b0, 1'b1);
      push_byte(8'h00, 1'b0, 1'b1);
      entries_done = entries_done + 8'd1;
      // a count lowered mid-section closes it on this entry
      if (entries_done == 8'd0 || entries_done >= cnt) begin
        c = crc;
        push_byte(c[31:24], 1'b0, 1'b0);
        push_byte(c[23:16], 1'b0, 1'b0);
        push_byte(c[15:8], 1'b0, 1'b0);
        push_byte(c[7:0], 1'b1, 1'b0);
        crc          = psg_pkg::CRC_INIT;
        entries_done = '0;
      end
    endfunction

    function void check_byte(logic [7:0] b, logic last);
      logic [8:0] want;
      if (section_bytes.size() == 0) begin
        $error("unexpected item: section_byte %h last_byte %b", b, last);
        errors++;
        return;
      end
      want = section_bytes.pop_front();
      if (b !== want[7:0]) begin
        $error("section_byte: expected %h, actual %h", want[7:0], b);
        errors++;
      end
      if (last !== want[8]) begin
        $error("last_byte: expected %b, actual %b", want[8], last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [7:0] st_code, [20:8] es_pid
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] section_byte
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  pmt_section_generator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pmt_scoreboard sb;
  bit            burst_mode = 1'b0;
  int unsigned   entries_sent = 0;

  always #5 clk_i = ~clk_i;

  function automatic bit take_gap();
    return !burst_mode && ($urandom_range(99) < GAP_PCT);
  endfunction

  function automatic logic [15:0] pick_value(int unsigned bits);
    logic [15:0] mask;
    mask = 16'((32'd1 << bits) - 1);
    case ($urandom_range(7))
      0: return 16'd0;
      1: return mask;
      default: return 16'($urandom) & mask;
    endcase
  endfunction

  always @(negedge clk_i) m_axis_tready <= rst_ni && !take_gap();

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_byte(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk_i);
    $display("** pmt_section_generator_core: FAILED **");
    $finish;
  end

  task automatic send_entry(input logic [7:0] st, input logic [12:0] pid);
    burst_mode = (entries_sent >= 150 && entries_sent < 250);
    while (take_gap()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, pid, st};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_entry(st, pid);
    entries_sent++;
    @(negedge clk_i);
  endtask

  // drop valid and wait until every expected byte is out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.section_bytes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned random_end;
    int unsigned phase_len;
    logic [15:0] data;

    sb = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset config, field extremes
    send_entry(8'h00, 13'h0000);
    send_entry(8'hFF, 13'h1FFF);
    settle();

    // upper bits of the pcr pid register masked; zero track count acts as one
    write_reg(psg_pkg::CFG_PROG_NUM, 16'hFFFF);
    write_reg(psg_pkg::CFG_PCR_PID, 16'hFFFF);
    write_reg(psg_pkg::CFG_TRACK_COUNT, 16'hFF00);
    send_entry(8'h1B, 13'h0100);
    send_entry(8'h0F, 13'h1001);
    settle();

    write_reg(CFG_SPARE, 16'h1234);
    write_reg(psg_pkg::CFG_PROG_NUM, 16'h0000);
    write_reg(psg_pkg::CFG_PCR_PID, 16'h0000);
    write_reg(psg_pkg::CFG_TRACK_COUNT, 16'h0003);
    send_entry(8'h02, 13'h0AAA);
    send_entry(8'h03, 13'h1555);
    send_entry(8'h07, 13'h0FFF);
    settle();

    // large count, then lowered below entries already sent
    write_reg(psg_pkg::CFG_TRACK_COUNT, 16'd201);
    repeat (4) send_entry(8'($urandom), 13'($urandom));
    settle();
    write_reg(psg_pkg::CFG_TRACK_COUNT, 16'd2);
    send_entry(8'h24, 13'h0123);
    settle();

    write_reg(psg_pkg::CFG_TRACK_COUNT, 16'hFFFF);
    repeat (2) send_entry(8'($urandom), 13'($urandom));
    settle();
    write_reg(psg_pkg::CFG_TRACK_COUNT, 16'd1);
    send_entry(8'h81, 13'h1FFE);
    settle();

    random_end = entries_sent + RANDOM_ENTRIES;
    while (entries_sent < random_end) begin
      if ($urandom_range(1)) write_reg(psg_pkg::CFG_PROG_NUM, pick_value(16));
      if ($urandom_range(1)) begin
        data = 16'($urandom);
        data[12:0] = 13'(pick_value(13));
        write_reg(psg_pkg::CFG_PCR_PID, data);
      end
      if ($urandom_range(3) != 0) begin
        data = 16'($urandom);
        case ($urandom_range(9))
          0: data[7:0] = 8'd0;
          1: data[7:0] = 8'd201;
          2: data[7:0] = 8'd255;
          default: data[7:0] = 8'($urandom_range(1, 6));
        endcase
        write_reg(psg_pkg::CFG_TRACK_COUNT, data);
      end
      phase_len = $urandom_range(1, 24);
      repeat (phase_len) send_entry(8'(pick_value(8)), 13'(pick_value(13)));
      settle();
    end

    if (sb.errors == 0 && sb.section_bytes.size() == 0) begin
      $display("** pmt_section_generator_core: PASSED **");
    end else begin
      $display("** pmt_section_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
